// ===== sv/bfdh_pkg.sv =====
// Shared types and constants for the double-hashing Bloom filter engine.
// Used by the probe generator, the bit memory and the top level.
`default_nettype none

package bfdh_pkg;

    localparam int PROBE_CNT_W = 6;
    localparam int BIT_CNT_W   = 17;
    localparam int HASH_W      = 64;
    localparam int HALF_W      = 32;
    localparam int WORD_W      = 32;
    localparam int BIT_POS_W   = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 17;
    localparam int OUT_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT   = 8'd1;

    localparam logic [PROBE_CNT_W-1:0] PROBE_COUNT_RST = 6'd7;
    localparam logic [BIT_CNT_W-1:0]   BIT_COUNT_RST   = 17'h10000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // One probe on its way from the generator to the bit memory.
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 query;
        logic [BIT_CNT_W-1:0] bit_idx;
    } t_probe_req;

    typedef struct packed {
        logic valid;
        logic present;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/bfdh_probe_gen.sv =====
// Probe sequencer: walks the double-hash probe sequence of one key and maps
// each probe onto the filter range. Depends on bfdh_pkg.
`default_nettype none

module bfdh_probe_gen (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_query,
    input  wire logic [bfdh_pkg::HASH_W-1:0]         i_hash,
    input  wire logic [bfdh_pkg::PROBE_CNT_W-1:0]    i_probe_count,
    input  wire logic [bfdh_pkg::BIT_CNT_W-1:0]      i_range,
    output logic                                     o_busy,
    output bfdh_pkg::t_probe_req                     o_req
);

    localparam int PROD_W = bfdh_pkg::HALF_W + bfdh_pkg::BIT_CNT_W;

    logic [bfdh_pkg::PROBE_CNT_W-1:0] r_left;
    logic [bfdh_pkg::HALF_W-1:0]      r_probe;
    logic [bfdh_pkg::HALF_W-1:0]      r_stride;
    logic                             r_query;
    logic                             r_first;
    bfdh_pkg::t_probe_req             r_req;
    logic [PROD_W-1:0]                w_prod;

    assign w_prod = {{bfdh_pkg::BIT_CNT_W{1'b0}}, r_probe}
                  * {{bfdh_pkg::HALF_W{1'b0}}, i_range};

    assign o_busy = (r_left != '0);
    assign o_req  = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_req.valid <= 1'b0;
        end else begin
            if (i_start) begin
                // A probe count of zero runs a single probe.
                r_left   <= (i_probe_count == '0) ? bfdh_pkg::PROBE_CNT_W'(1) : i_probe_count;
                r_probe  <= i_hash[bfdh_pkg::HASH_W-1:bfdh_pkg::HALF_W];
                r_stride <= i_hash[bfdh_pkg::HALF_W-1:0] | bfdh_pkg::HALF_W'(1);
                r_query  <= i_query;
                r_first  <= 1'b1;
            end else if (r_left != '0) begin
                r_probe <= r_probe + r_stride;
                r_left  <= r_left - bfdh_pkg::PROBE_CNT_W'(1);
                r_first <= 1'b0;
            end
            r_req.valid   <= (r_left != '0) && !i_start;
            r_req.first   <= r_first;
            r_req.last    <= (r_left == bfdh_pkg::PROBE_CNT_W'(1));
            r_req.query   <= r_query;
            r_req.bit_idx <= w_prod[PROD_W-1:bfdh_pkg::HALF_W];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bfdh_bit_mem.sv =====
// Filter bit memory with read-modify-write, one-deep write forwarding and a
// clearing pass after reset. Depends on bfdh_pkg.
`default_nettype none

module bfdh_bit_mem #(
    parameter int WORDS = 2048,
    parameter int AW    = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bfdh_pkg::t_probe_req i_req,
    output logic                      o_clearing,
    output bfdh_pkg::t_result         o_res
);

    logic [bfdh_pkg::WORD_W-1:0] mem [WORDS];

    logic                           r_clearing;
    logic [AW-1:0]                  r_clr_addr;
    logic                           r_s2_valid;
    logic                           r_s2_first;
    logic                           r_s2_last;
    logic                           r_s2_query;
    logic [AW-1:0]                  r_s2_addr;
    logic [bfdh_pkg::BIT_POS_W-1:0] r_s2_bit;
    logic [bfdh_pkg::WORD_W-1:0]    r_rdata;
    logic                           r_fwd_valid;
    logic [AW-1:0]                  r_fwd_addr;
    logic [bfdh_pkg::WORD_W-1:0]    r_fwd_data;
    logic                           r_acc;

    logic [AW-1:0]                  w_rd_addr;
    logic [bfdh_pkg::WORD_W-1:0]    w_cur;
    logic [bfdh_pkg::WORD_W-1:0]    w_merged;
    logic                           w_acc;
    logic                           w_upd;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [bfdh_pkg::WORD_W-1:0]    w_wdata;

    assign w_rd_addr = AW'(i_req.bit_idx >> bfdh_pkg::BIT_POS_W);

    // The memory read still returns stale data for a word that the update just ahead of this one wrote.
    assign w_cur    = (r_fwd_valid && (r_fwd_addr == r_s2_addr)) ? r_fwd_data : r_rdata;
    assign w_merged = w_cur | (bfdh_pkg::WORD_W'(1) << r_s2_bit);
    assign w_acc    = (r_s2_first | r_acc) & w_cur[r_s2_bit];
    assign w_upd    = r_s2_valid && !r_s2_query;

    assign w_we    = r_clearing || w_upd;
    assign w_waddr = r_clearing ? r_clr_addr : r_s2_addr;
    assign w_wdata = r_clearing ? '0 : w_merged;

    assign o_clearing    = r_clearing;
    assign o_res.valid   = r_s2_valid && r_s2_query && r_s2_last;
    assign o_res.present = w_acc;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s2_valid  <= i_req.valid;
            r_s2_first  <= i_req.first;
            r_s2_last   <= i_req.last;
            r_s2_query  <= i_req.query;
            r_s2_addr   <= w_rd_addr;
            r_s2_bit    <= i_req.bit_idx[bfdh_pkg::BIT_POS_W-1:0];
            r_fwd_valid <= w_upd;
            r_fwd_addr  <= r_s2_addr;
            r_fwd_data  <= w_merged;
            if (r_s2_valid && r_s2_query) begin
                r_acc <= w_acc;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bloom_filter_double_hash_unit.sv =====
// Channel   | Direction | Payload
// s_axis    | in        | tdata: key_hash[63:0]; tuser: opcode (1 = query)
// m_axis    | out       | tdata: maybe_present in bit 0, bits 7:1 zero
// cfg       | in        | index 0 probe_count, index 1 bit_count
//
// An item holds the input while the probe sequencer issues its max(probe_count, 1)
// probes, one memory access per cycle; probe_count is 7 at reset.
// A query answer is offered at the output once its last probe has passed the
// probe request register and the memory read stage into the output queue.
// After reset a clearing pass zeroes all (MAX_FILTER_BITS+31)/32 memory words
// (2048 by default) while no item is accepted; config writes are always taken.
// One query answer can wait at the output while the next item is accepted;
// with two answers outstanding the input stalls until one of them leaves.
// Top level of the double-hashing Bloom filter engine.
// Depends on bfdh_pkg, bfdh_probe_gen and bfdh_bit_mem.
`default_nettype none

module bloom_filter_double_hash_unit #(
    parameter int MAX_FILTER_BITS = 65536
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [bfdh_pkg::HASH_W-1:0]          i_s_axis_tdata,  // key_hash
    input  wire logic [0:0]                           i_s_axis_tuser,  // opcode
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic [bfdh_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,  // maybe_present
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int WORDS = (MAX_FILTER_BITS + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [24:0] MAX_BITS = 25'(MAX_FILTER_BITS);

    logic [bfdh_pkg::PROBE_CNT_W-1:0] r_probe_count;
    logic [bfdh_pkg::BIT_CNT_W-1:0]   r_bit_count;
    logic [1:0]                       r_pend;
    logic [1:0]                       r_q_cnt;
    logic                             r_q0;
    logic                             r_q1;

    logic [bfdh_pkg::BIT_CNT_W-1:0]   w_range;
    logic                             w_busy;
    logic                             w_clearing;
    logic                             w_in_acc;
    logic                             w_pop;
    logic                             w_push;
    bfdh_pkg::t_probe_req             w_req;
    bfdh_pkg::t_result                w_res;

    assign w_range = ({8'b0, r_bit_count} > MAX_BITS) ? MAX_BITS[bfdh_pkg::BIT_CNT_W-1:0]
                                                      : r_bit_count;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !w_busy && !w_clearing && (r_pend != 2'd2);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_q_cnt != 2'd0);
    assign o_m_axis_tdata  = {{(bfdh_pkg::OUT_DATA_W-1){1'b0}}, r_q0};
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign w_push          = w_res.valid;

    bfdh_probe_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_in_acc),
        .i_query       (i_s_axis_tuser[0] == bfdh_pkg::OP_QUERY),
        .i_hash        (i_s_axis_tdata),
        .i_probe_count (r_probe_count),
        .i_range       (w_range),
        .o_busy        (w_busy),
        .o_req         (w_req)
    );

    bfdh_bit_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_clearing (w_clearing),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_count <= bfdh_pkg::PROBE_COUNT_RST;
            r_bit_count   <= bfdh_pkg::BIT_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == bfdh_pkg::CFG_PROBE_COUNT) begin
                r_probe_count <= i_cfg_data[bfdh_pkg::PROBE_CNT_W-1:0];
            end else if (i_cfg_index == bfdh_pkg::CFG_BIT_COUNT) begin
                r_bit_count <= i_cfg_data;
            end
        end
    end

    // Each accepted query reserves one of the two output slots until its
    // answer leaves, so the queue below can never overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 2'd0;
            r_q_cnt <= 2'd0;
        end else begin
            r_pend <= r_pend
                    + 2'((w_in_acc && (i_s_axis_tuser[0] == bfdh_pkg::OP_QUERY)) ? 1 : 0)
                    - 2'(w_pop ? 1 : 0);
            r_q_cnt <= r_q_cnt + 2'(w_push ? 1 : 0) - 2'(w_pop ? 1 : 0);
            if (w_pop) begin
                r_q0 <= (r_q_cnt == 2'd2) ? r_q1 : w_res.present;
                if (w_push) begin
                    r_q1 <= w_res.present;
                end
            end else if (w_push) begin
                if (r_q_cnt == 2'd0) begin
                    r_q0 <= w_res.present;
                end else begin
                    r_q1 <= w_res.present;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bfdh_checker.sv =====
// Port-level checks for the Bloom filter engine, bound to its top level.
// Depends on bloom_filter_double_hash_unit and bfdh_pkg.
`default_nettype none

module bfdh_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    input  wire logic                              o_s_axis_tready,
    input  wire logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    input  wire logic [bfdh_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    // The memory clearing pass blocks input right after reset.
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |=> !o_s_axis_tready)
        else $error("input accepted during the clearing pass");

    // Input is not taken again right after a key is accepted, while its probes are issued.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while probes were still being issued");

endmodule

bind bloom_filter_double_hash_unit bfdh_checker u_bfdh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== test/tb_bloom_filter_double_hash_unit.sv =====
// Self-checking testbench for bloom_filter_double_hash_unit: inserts and queries keys
// and compares every query answer with a bit-accurate filter model kept in the bench.
// Depends on bfdh_pkg and the RTL of the engine; reads no files.
`timescale 1ns / 100ps

module tb_bloom_filter_double_hash_unit;

    localparam int FILTER_BITS  = 65536;
    localparam int DRAIN_CYCLES = 100;  // longest probe run (63 probes) plus output pipeline
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_DEPTH   = 256;

    // Register indexes that map to no register; writes to them must be ignored.
    localparam logic [bfdh_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd2;
    localparam logic [bfdh_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

    typedef struct packed {
        logic                        opcode;
        logic [bfdh_pkg::HASH_W-1:0] key_hash;
    } t_key_req;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic [bfdh_pkg::HASH_W-1:0]         s_tdata = '0;
    logic [0:0]                          s_tuser = '0;
    logic                                m_tready = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic [bfdh_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [bfdh_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    wire                                 o_s_axis_tready;
    wire                                 o_m_axis_tvalid;
    wire [bfdh_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata;
    wire                                 o_cfg_ready;

    // Filter model and its copy of the registers.
    bit                                  filter_bits [FILTER_BITS];
    logic [bfdh_pkg::PROBE_CNT_W-1:0]    probes_cfg = bfdh_pkg::PROBE_COUNT_RST;
    logic [bfdh_pkg::BIT_CNT_W-1:0]      range_cfg  = bfdh_pkg::BIT_COUNT_RST;

    t_key_req                            key_req_q [$];
    logic                                answer_q [$];
    logic [bfdh_pkg::HASH_W-1:0]         inserted_keys [$];
    t_key_req                            next_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int keys_queued   = 0;
    int keys_accepted = 0;
    int insert_count  = 0;
    int query_count   = 0;
    int hit_count     = 0;
    int answer_count  = 0;
    int reg_writes    = 0;
    int mismatch_count = 0;

    bloom_filter_double_hash_unit #(
        .MAX_FILTER_BITS(FILTER_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),     // key_hash[63:0]
        .i_s_axis_tuser  (s_tuser),     // opcode
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata), // maybe_present, zero fill
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walks the probe sequence of one key: sets the bits for an insert, and for a
    // query pushes whether every probed bit was already set.
    task automatic apply_key(input logic opcode, input logic [bfdh_pkg::HASH_W-1:0] key_hash);
        logic [bfdh_pkg::HALF_W-1:0]    probe;
        logic [bfdh_pkg::HALF_W-1:0]    stride;
        logic [bfdh_pkg::BIT_CNT_W-1:0] range;
        logic [63:0]                    product;
        int unsigned                    n_probes;
        int unsigned                    bit_idx;
        int unsigned                    i;
        bit                             all_set;
        probe    = key_hash[bfdh_pkg::HASH_W-1:bfdh_pkg::HALF_W];
        stride   = key_hash[bfdh_pkg::HALF_W-1:0] | 32'd1;
        n_probes = (probes_cfg == '0) ? 32'd1 : 32'(probes_cfg);
        range    = (range_cfg > FILTER_BITS) ? bfdh_pkg::BIT_CNT_W'(FILTER_BITS) : range_cfg;
        all_set  = 1'b1;
        for (i = 0; i < n_probes; i++) begin
            product = 64'(probe) * 64'(range);
            bit_idx = 32'(product[47:32]);
            if (opcode == bfdh_pkg::OP_QUERY) begin
                if (!filter_bits[bit_idx])
                    all_set = 1'b0;
            end else begin
                filter_bits[bit_idx] = 1'b1;
            end
            probe = probe + stride;
        end
        if (opcode == bfdh_pkg::OP_QUERY) begin
            answer_q.push_back(all_set);
            query_count++;
            if (all_set)
                hit_count++;
        end else begin
            insert_count++;
        end
    endtask

    // Sender: one beat in flight at most, refilled from key_req_q.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                apply_key(s_tuser[0], s_tdata);
                keys_accepted++;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (key_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = key_req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.key_hash;
                    s_tuser  <= next_req.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what,
                                 input logic [bfdh_pkg::OUT_DATA_W-1:0] want,
                                 input logic [bfdh_pkg::OUT_DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Receiver: checks every answer beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                answer_count++;
                if (answer_q.size() == 0)
                    note_mismatch("answer with no query pending", 'x, o_m_axis_tdata);
                else if (o_m_axis_tdata !== {{(bfdh_pkg::OUT_DATA_W-1){1'b0}}, answer_q[0]})
                    note_mismatch("maybe_present",
                                  {{(bfdh_pkg::OUT_DATA_W-1){1'b0}}, answer_q[0]},
                                  o_m_axis_tdata);
                if (answer_q.size() != 0)
                    void'(answer_q.pop_front());
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfdh_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == bfdh_pkg::CFG_PROBE_COUNT)
            probes_cfg = data[bfdh_pkg::PROBE_CNT_W-1:0];
        else if (idx == bfdh_pkg::CFG_BIT_COUNT)
            range_cfg = data;
    endtask

    task automatic queue_key(input logic opcode, input logic [bfdh_pkg::HASH_W-1:0] key_hash);
        t_key_req req;
        req.opcode   = opcode;
        req.key_hash = key_hash;
        key_req_q.push_back(req);
        keys_queued++;
        if (opcode == bfdh_pkg::OP_INSERT) begin
            inserted_keys.push_back(key_hash);
            if (inserted_keys.size() > POOL_DEPTH)
                void'(inserted_keys.pop_front());
        end
    endtask

    // Waits until every key is taken and answered, then lets a trailing insert finish.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (keys_accepted != keys_queued || answer_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [bfdh_pkg::HASH_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Mostly inserts and queries of keys already inserted, the rest unrelated queries.
    task automatic queue_random_keys(input int n_keys);
        int k;
        int pick;
        for (k = 0; k < n_keys; k++) begin
            pick = $urandom_range(99);
            if (pick < 45 || inserted_keys.size() == 0)
                queue_key(bfdh_pkg::OP_INSERT, random_key());
            else if (pick < 80)
                queue_key(bfdh_pkg::OP_QUERY,
                          inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
            else
                queue_key(bfdh_pkg::OP_QUERY, random_key());
        end
    endtask

    task automatic write_random_config();
        logic [bfdh_pkg::PROBE_CNT_W-1:0] probes;
        logic [bfdh_pkg::BIT_CNT_W-1:0]   range;
        case ($urandom_range(9))
            0:       probes = '0;
            1:       probes = 6'($urandom_range(33, 63));
            2:       probes = 6'd32;
            default: probes = 6'($urandom_range(1, 10));
        endcase
        case ($urandom_range(7))
            0:       range = bfdh_pkg::BIT_CNT_W'(FILTER_BITS);
            1:       range = bfdh_pkg::BIT_CNT_W'($urandom_range(FILTER_BITS + 1, 131071));
            2:       range = bfdh_pkg::BIT_CNT_W'($urandom_range(1, 64));
            default: range = bfdh_pkg::BIT_CNT_W'($urandom_range(65, 8192));
        endcase
        // The upper data bits of a probe_count write are don't-care to the block.
        write_reg(bfdh_pkg::CFG_PROBE_COUNT, {11'($urandom_range(0, 2047)), probes});
        write_reg(bfdh_pkg::CFG_BIT_COUNT, range);
    endtask

    initial begin
        int chunk;
        logic [bfdh_pkg::HASH_W-1:0] key;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 30;
        recv_idle_pct = 61;

        // Reset settings: empty filter, all-zero and all-one hashes, even stride halves.
        queue_key(bfdh_pkg::OP_QUERY, 64'h0);
        queue_key(bfdh_pkg::OP_INSERT, 64'h0);
        queue_key(bfdh_pkg::OP_QUERY, 64'h0);
        queue_key(bfdh_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_key(bfdh_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_key(bfdh_pkg::OP_QUERY, 64'hFFFF_FFFF_0000_0000);
        queue_key(bfdh_pkg::OP_QUERY, 64'h8000_0000_0000_0001);
        wait_idle();

        // Zero probe count acts as one probe; zero bit count maps all probes to bit 0.
        write_reg(bfdh_pkg::CFG_PROBE_COUNT, '0);
        write_reg(bfdh_pkg::CFG_BIT_COUNT, '0);
        key = random_key();
        queue_key(bfdh_pkg::OP_QUERY, key);
        queue_key(bfdh_pkg::OP_INSERT, key);
        queue_key(bfdh_pkg::OP_QUERY, random_key());
        wait_idle();

        // Probe count above 32 taken as is, bit count above the store saturates.
        write_reg(bfdh_pkg::CFG_PROBE_COUNT, '1);
        write_reg(bfdh_pkg::CFG_BIT_COUNT, '1);
        key = random_key();
        queue_key(bfdh_pkg::OP_INSERT, key);
        queue_key(bfdh_pkg::OP_QUERY, key);
        queue_key(bfdh_pkg::OP_QUERY, random_key());
        wait_idle();

        // One-bit filter with a probe count of 32.
        write_reg(bfdh_pkg::CFG_PROBE_COUNT, 17'd32);
        write_reg(bfdh_pkg::CFG_BIT_COUNT, 17'd1);
        queue_key(bfdh_pkg::OP_QUERY, random_key());
        queue_key(bfdh_pkg::OP_INSERT, random_key());
        queue_key(bfdh_pkg::OP_QUERY, random_key());
        wait_idle();

        // Writes to unmapped indexes must leave both registers alone.
        write_reg(bfdh_pkg::CFG_PROBE_COUNT, 17'd1);
        write_reg(bfdh_pkg::CFG_BIT_COUNT, 17'd65536);
        write_reg(CFG_IDX_UNUSED, '1);
        write_reg(CFG_IDX_TOP, 17'h15555);
        key = random_key();
        queue_key(bfdh_pkg::OP_QUERY, key);
        queue_key(bfdh_pkg::OP_INSERT, key);
        queue_key(bfdh_pkg::OP_QUERY, key);
        queue_key(bfdh_pkg::OP_QUERY, 64'h0000_0001_FFFF_FFFE);
        wait_idle();

        for (chunk = 0; chunk < 6; chunk++) begin
            case (chunk / 2)
                0: begin send_idle_pct = 30; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_random_config();
            queue_random_keys(108);
            wait_idle();
        end

        $display("Covered %0d inserts and %0d queries (%0d answered present)",
                 insert_count, query_count, hit_count);
        $display("across %0d register writes; answer beats checked: %0d, mismatches: %0d.",
                 reg_writes, answer_count, mismatch_count);
        if (mismatch_count == 0 && answer_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d keys unaccepted and %0d answers outstanding.",
                 keys_queued - keys_accepted, answer_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
